// ===== rtl/core/nac_pkg.sv =====
// Shared constants, codes and interface structs of the namespace access checker.
`default_nettype none

package nac_pkg;

    // Table sizes and counter width.
    localparam int MAX_PROCS  = 32;
    localparam int MAX_NS     = 16;
    localparam int COUNT_BITS = 16;

    // Index and fill-count widths that follow from the table sizes.
    localparam int NS_IDX_W   = $clog2(MAX_NS);
    localparam int NS_CNT_W   = $clog2(MAX_NS + 1);
    localparam int PROC_IDX_W = $clog2(MAX_PROCS);
    localparam int PROC_CNT_W = $clog2(MAX_PROCS + 1);

    // Fixed field widths of the item and result ports.
    localparam int OP_W    = 2;
    localparam int TYPE_W  = 4;
    localparam int POL_W   = 2;
    localparam int CAP_W   = 5;
    localparam int IDX_W   = 5;
    localparam int ISO_W   = 2;
    localparam int TOTAL_W = 16;

    // Root namespace and capability constants.
    localparam logic [NS_IDX_W-1:0] ROOT_NS      = '0;
    localparam int                  ROOT_CAP_BIT = 4;
    localparam logic [TYPE_W-1:0]   ALL_TYPES    = 4'hF;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Access and policy codes.
    localparam logic [POL_W-1:0] POL_DENIED    = 2'd0;
    localparam logic [POL_W-1:0] POL_SANDBOXED = 2'd1;
    localparam logic [POL_W-1:0] POL_GRANTED   = 2'd2;

    // Isolation codes.
    localparam logic [ISO_W-1:0] ISO_SHARED   = 2'd0;
    localparam logic [ISO_W-1:0] ISO_ISOLATED = 2'd1;
    localparam logic [ISO_W-1:0] ISO_UNKNOWN  = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE = 2'd0,
        OP_SPAWN  = 2'd1,
        OP_CHECK  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // One registered item.
    typedef struct packed {
        logic                  valid;
        t_op                   op;
        logic [TYPE_W-1:0]     type_bits;
        logic [POL_W-1:0]      policy;
        logic [NS_IDX_W-1:0]   home;
        logic [CAP_W-1:0]      caps;
        logic [PROC_IDX_W-1:0] slot;
        logic [NS_IDX_W-1:0]   target;
    } t_item;

    typedef struct packed {
        logic              en;
        logic [TYPE_W-1:0] types;
        logic [POL_W-1:0]  policy;
    } t_ns_wr;

    typedef struct packed {
        logic [NS_CNT_W-1:0] used;
        logic [TYPE_W-1:0]   tgt_types;
        logic [POL_W-1:0]    tgt_policy;
    } t_ns_view;

    typedef struct packed {
        logic                en;
        logic [NS_IDX_W-1:0] home;
        logic [CAP_W-1:0]    caps;
    } t_proc_wr;

    typedef struct packed {
        logic [PROC_CNT_W-1:0] used;
        logic [NS_IDX_W-1:0]   slot_home;
        logic [CAP_W-1:0]      slot_caps;
    } t_proc_view;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] idx;
        logic [POL_W-1:0] acc;
        logic [ISO_W-1:0] iso;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/nac_ns_table.sv =====
// Namespace table: type masks, policies and the fill count.
`default_nettype none

module nac_ns_table (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire nac_pkg::t_ns_wr              i_wr,
    input  wire logic [nac_pkg::NS_IDX_W-1:0] i_tgt,
    output nac_pkg::t_ns_view                 o_view
);
    import nac_pkg::*;

    logic [TYPE_W-1:0]   r_types [MAX_NS];
    logic [POL_W-1:0]    r_pol   [MAX_NS];
    logic [NS_CNT_W-1:0] r_used;
    logic [NS_CNT_W-1:0] n_used;

    assign n_used = r_used + NS_CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= NS_CNT_W'(1);
        end else if (i_wr.en) begin
            r_used <= n_used;
        end
    end

    // Entry 0 is never written: the root entry is supplied as constants below.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_types[r_used[NS_IDX_W-1:0]] <= i_wr.types;
            r_pol[r_used[NS_IDX_W-1:0]]   <= i_wr.policy;
        end
    end

    always_comb begin
        o_view.used = r_used;
        if (i_tgt == ROOT_NS) begin
            o_view.tgt_types  = ALL_TYPES;
            o_view.tgt_policy = POL_GRANTED;
        end else begin
            o_view.tgt_types  = r_types[i_tgt];
            o_view.tgt_policy = r_pol[i_tgt];
        end
    end

`ifndef SYNTHESIS
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used >= NS_CNT_W'(1)) && (r_used <= NS_CNT_W'(MAX_NS)))
        else $error("namespace fill count out of range");

    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.en |-> (r_used < NS_CNT_W'(MAX_NS)))
        else $error("namespace write into a full table");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/nac_proc_table.sv =====
// Process table: home namespace and capabilities of each process, and the fill count.
`default_nettype none

module nac_proc_table (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire nac_pkg::t_proc_wr              i_wr,
    input  wire logic [nac_pkg::PROC_IDX_W-1:0] i_slot,
    output nac_pkg::t_proc_view                 o_view
);
    import nac_pkg::*;

    logic [NS_IDX_W-1:0]   r_home [MAX_PROCS];
    logic [CAP_W-1:0]      r_caps [MAX_PROCS];
    logic [PROC_CNT_W-1:0] r_used;
    logic [PROC_CNT_W-1:0] n_used;

    assign n_used = r_used + PROC_CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_wr.en) begin
            r_used <= n_used;
        end
    end

    // Entries at or above the fill count are never consulted.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_home[r_used[PROC_IDX_W-1:0]] <= i_wr.home;
            r_caps[r_used[PROC_IDX_W-1:0]] <= i_wr.caps;
        end
    end

    always_comb begin
        o_view.used      = r_used;
        o_view.slot_home = r_home[i_slot];
        o_view.slot_caps = r_caps[i_slot];
    end

endmodule

`default_nettype wire

// ===== rtl/core/nac_decide.sv =====
// Per-item decision logic, saturating totals and the result register.
`default_nettype none

module nac_decide (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire nac_pkg::t_item               i_item,
    input  wire nac_pkg::t_ns_view            i_ns,
    input  wire nac_pkg::t_proc_view          i_proc,
    output nac_pkg::t_ns_wr                   o_ns_wr,
    output nac_pkg::t_proc_wr                 o_proc_wr,
    output logic                              o_strobe,
    output nac_pkg::t_result                  o_res,
    output logic [nac_pkg::TOTAL_W-1:0]       o_viol_total,
    output logic [nac_pkg::TOTAL_W-1:0]       o_sbx_total
);
    import nac_pkg::*;

    logic slot_ok;
    logic tgt_ok;
    logic home_ok;
    logic ns_full;
    logic proc_full;
    logic root_refused;
    logic spawn_hits_slot;
    logic inc_sbx;
    logic inc_viol;

    t_result n_res;
    t_result r_res;
    logic    r_strobe;

    logic [COUNT_BITS-1:0] r_viol;
    logic [COUNT_BITS-1:0] r_sbx;
    logic [COUNT_BITS-1:0] n_viol;
    logic [COUNT_BITS-1:0] n_sbx;

    assign slot_ok   = PROC_CNT_W'(i_item.slot) < i_proc.used;
    assign tgt_ok    = NS_CNT_W'(i_item.target) < i_ns.used;
    assign home_ok   = NS_CNT_W'(i_item.home) < i_ns.used;
    assign ns_full   = i_ns.used == NS_CNT_W'(MAX_NS);
    assign proc_full = i_proc.used == PROC_CNT_W'(MAX_PROCS);
    assign root_refused    = (i_item.home == ROOT_NS) && !i_item.caps[ROOT_CAP_BIT];
    assign spawn_hits_slot = PROC_CNT_W'(i_item.slot) == i_proc.used;

    always_comb begin
        n_res.ok  = 1'b0;
        n_res.idx = '0;
        n_res.acc = POL_DENIED;
        inc_sbx   = 1'b0;
        inc_viol  = 1'b0;

        o_ns_wr.en    = 1'b0;
        o_ns_wr.types = i_item.type_bits;
        // An unknown policy code is stored as denied.
        if (i_item.policy inside {POL_DENIED, POL_SANDBOXED, POL_GRANTED}) begin
            o_ns_wr.policy = i_item.policy;
        end else begin
            o_ns_wr.policy = POL_DENIED;
        end

        o_proc_wr.en   = 1'b0;
        o_proc_wr.home = i_item.home;
        o_proc_wr.caps = i_item.caps;

        if (i_item.valid) begin
            case (i_item.op)
                OP_CREATE: begin
                    if (!ns_full) begin
                        o_ns_wr.en = 1'b1;
                        n_res.ok   = 1'b1;
                        n_res.idx  = IDX_W'(i_ns.used);
                    end
                end
                OP_SPAWN: begin
                    if (!proc_full && home_ok && !root_refused) begin
                        o_proc_wr.en = 1'b1;
                        n_res.ok     = 1'b1;
                        n_res.idx    = IDX_W'(i_proc.used);
                    end
                end
                OP_CHECK: begin
                    if (slot_ok && tgt_ok) begin
                        n_res.ok = 1'b1;
                        if (i_proc.slot_home == ROOT_NS) begin
                            n_res.acc = POL_GRANTED;
                            inc_sbx   = i_item.target != ROOT_NS;
                        end else if (i_proc.slot_home == i_item.target) begin
                            n_res.acc = i_ns.tgt_policy;
                        end else if ((i_proc.slot_caps[TYPE_W-1:0] & i_ns.tgt_types) != '0)
                        begin
                            n_res.acc = POL_SANDBOXED;
                            inc_sbx   = 1'b1;
                        end else begin
                            n_res.acc = POL_DENIED;
                            inc_viol  = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // Isolation is reported after this item's own table update.
        if (slot_ok) begin
            n_res.iso = (i_proc.slot_home != ROOT_NS) ? ISO_ISOLATED : ISO_SHARED;
        end else if (o_proc_wr.en && spawn_hits_slot) begin
            n_res.iso = (i_item.home != ROOT_NS) ? ISO_ISOLATED : ISO_SHARED;
        end else begin
            n_res.iso = ISO_UNKNOWN;
        end
    end

    assign n_viol = (inc_viol && (r_viol != COUNT_MAX)) ? r_viol + COUNT_BITS'(1) : r_viol;
    assign n_sbx  = (inc_sbx && (r_sbx != COUNT_MAX)) ? r_sbx + COUNT_BITS'(1) : r_sbx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_viol   <= '0;
            r_sbx    <= '0;
        end else begin
            r_strobe <= i_item.valid;
            r_viol   <= n_viol;
            r_sbx    <= n_sbx;
        end
        r_res <= n_res;
    end

    assign o_strobe     = r_strobe;
    assign o_res        = r_res;
    assign o_viol_total = r_viol[TOTAL_W-1:0];
    assign o_sbx_total  = r_sbx[TOTAL_W-1:0];

`ifndef SYNTHESIS
    a_totals_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_viol >= $past(r_viol)) && (r_sbx >= $past(r_sbx)))
        else $error("a saturating total went backwards");

    a_one_total_per_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> !((r_viol != $past(r_viol)) && (r_sbx != $past(r_sbx))))
        else $error("one item moved both totals");

    a_access_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && (r_res.acc != POL_DENIED)) |-> r_res.ok)
        else $error("access given without a valid check");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/namespace_access_checker_top.sv =====
// Top level of the namespace access checker: input register and table/decision wiring.
`default_nettype none

// The block keeps a namespace table and a process table and answers three kinds of
// item: create a namespace, spawn a process into a namespace, and check whether a
// process may reach a namespace. Every item gives exactly one result.
//
// An item is taken at a rising edge where start is high and busy is low. Busy is
// never raised, so one item can be taken at every edge.
// The item is first captured in an input register; the decision, the table write
// and the totals update then happen in the following cycle, and the result is shown
// on the o_ ports for exactly one cycle, marked by o_strobe. An item thus passes
// through the input register and then the result register: one item a cycle. The
// tables are updated at the same edge that loads the result register, so the next
// item always sees the updated tables. The receiver cannot hold results off; a new
// result simply follows the next cycle.
//
// Reset is synchronous and active low. It empties the process table, leaves only the
// root namespace in the namespace table, clears both totals and drops any item in
// flight. Table contents above the fill counts are never read, so they need no reset.
module namespace_access_checker_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [nac_pkg::OP_W-1:0]       i_operation,
    input  wire logic [nac_pkg::TYPE_W-1:0]     i_new_type_mask,
    input  wire logic [nac_pkg::POL_W-1:0]      i_new_policy,
    input  wire logic [nac_pkg::NS_IDX_W-1:0]   i_home_ns,
    input  wire logic [nac_pkg::CAP_W-1:0]      i_capability_bits,
    input  wire logic [nac_pkg::PROC_IDX_W-1:0] i_process_slot,
    input  wire logic [nac_pkg::NS_IDX_W-1:0]   i_target_namespace,
    output logic                                o_strobe,
    output logic                                o_ok,
    output logic [nac_pkg::IDX_W-1:0]           o_assigned_index,
    output logic [nac_pkg::POL_W-1:0]           o_access_result,
    output logic [nac_pkg::ISO_W-1:0]           o_isolation,
    output logic [nac_pkg::TOTAL_W-1:0]         o_violation_total,
    output logic [nac_pkg::TOTAL_W-1:0]         o_sandboxed_total
);
    import nac_pkg::*;

    t_item      r_item;
    t_ns_wr     ns_wr;
    t_ns_view   ns_view;
    t_proc_wr   proc_wr;
    t_proc_view proc_view;
    t_result    res;

    // Every stage moves each cycle, so the block is always ready.
    assign busy = 1'b0;

    // Input register. Only the valid flag needs a reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else begin
            r_item.valid <= start && !busy;
        end
        r_item.op        <= t_op'(i_operation);
        r_item.type_bits <= i_new_type_mask;
        r_item.policy    <= i_new_policy;
        r_item.home      <= i_home_ns;
        r_item.caps      <= i_capability_bits;
        r_item.slot      <= i_process_slot;
        r_item.target    <= i_target_namespace;
    end

    nac_ns_table u_ns_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (ns_wr),
        .i_tgt   (r_item.target),
        .o_view  (ns_view)
    );

    nac_proc_table u_proc_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (proc_wr),
        .i_slot  (r_item.slot),
        .o_view  (proc_view)
    );

    nac_decide u_decide (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (r_item),
        .i_ns         (ns_view),
        .i_proc       (proc_view),
        .o_ns_wr      (ns_wr),
        .o_proc_wr    (proc_wr),
        .o_strobe     (o_strobe),
        .o_res        (res),
        .o_viol_total (o_violation_total),
        .o_sbx_total  (o_sandboxed_total)
    );

    assign o_ok             = res.ok;
    assign o_assigned_index = res.idx;
    assign o_access_result  = res.acc;
    assign o_isolation      = res.iso;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking namespace access checker testbench: directed, random, table-full, back-to-back.
`timescale 1ns / 100ps

module tb_top;

    import nac_pkg::*;

    // Run control. The sender never waits longer than GAP_MAX between items, and the
    // block answers every item that it takes, so a watchdog count of STALL_LIMIT without
    // any handshake or result can only mean that the block has hung.
    localparam int GAP_MAX      = 19;
    localparam int STALL_LIMIT  = 400;
    localparam int RANDOM_ITEMS = 1000;
    localparam int BURST_ROUNDS = 32;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_LINES = 100;

    // Policy code three has no meaning; the block stores it as denied.
    localparam logic [POL_W-1:0] POL_UNDEFINED = 2'd3;

    // Process slots that the directed test always fills first. Slot 0 lives in root
    // with the root capability, slot 1 lives in namespace 1 with no capabilities at
    // all, so its accesses to root are always denied.
    localparam int ROOT_SLOT    = 0;
    localparam int CLOSED_SLOT  = 1;
    localparam int FOREIGN_NS   = 2;

    // One item as it is presented on the input ports.
    typedef struct {
        t_op                   op;
        logic [TYPE_W-1:0]     type_bits;
        logic [POL_W-1:0]      policy;
        logic [NS_IDX_W-1:0]   home;
        logic [CAP_W-1:0]      caps;
        logic [PROC_IDX_W-1:0] slot;
        logic [NS_IDX_W-1:0]   target;
    } request_t;

    // The result that one item must produce.
    typedef struct {
        logic               ok;
        logic [IDX_W-1:0]   idx;
        logic [POL_W-1:0]   acc;
        logic [ISO_W-1:0]   iso;
        logic [TOTAL_W-1:0] violations;
        logic [TOTAL_W-1:0] sandboxed;
    } verdict_t;

    logic                  i_clk              = 1'b0;
    logic                  i_rst_n            = 1'b0;
    logic                  start              = 1'b0;
    logic [OP_W-1:0]       i_operation        = '0;
    logic [TYPE_W-1:0]     i_new_type_mask    = '0;
    logic [POL_W-1:0]      i_new_policy       = '0;
    logic [NS_IDX_W-1:0]   i_home_ns          = '0;
    logic [CAP_W-1:0]      i_capability_bits  = '0;
    logic [PROC_IDX_W-1:0] i_process_slot     = '0;
    logic [NS_IDX_W-1:0]   i_target_namespace = '0;

    logic                  busy;
    logic                  o_strobe;
    logic                  o_ok;
    logic [IDX_W-1:0]      o_assigned_index;
    logic [POL_W-1:0]      o_access_result;
    logic [ISO_W-1:0]      o_isolation;
    logic [TOTAL_W-1:0]    o_violation_total;
    logic [TOTAL_W-1:0]    o_sandboxed_total;

    namespace_access_checker_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_operation        (i_operation),
        .i_new_type_mask    (i_new_type_mask),
        .i_new_policy       (i_new_policy),
        .i_home_ns          (i_home_ns),
        .i_capability_bits  (i_capability_bits),
        .i_process_slot     (i_process_slot),
        .i_target_namespace (i_target_namespace),
        .o_strobe           (o_strobe),
        .o_ok               (o_ok),
        .o_assigned_index   (o_assigned_index),
        .o_access_result    (o_access_result),
        .o_isolation        (o_isolation),
        .o_violation_total  (o_violation_total),
        .o_sandboxed_total  (o_sandboxed_total)
    );

    // 12 ns clock period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // The testbench's own copy of the block's tables and totals. It is advanced once
    // for every item that the block takes, in the order the items are taken.
    logic [TYPE_W-1:0]     ns_type_copy   [MAX_NS];
    logic [POL_W-1:0]      ns_policy_copy [MAX_NS];
    logic [NS_IDX_W-1:0]   proc_home_copy [MAX_PROCS];
    logic [CAP_W-1:0]      proc_caps_copy [MAX_PROCS];
    int                    ns_fill        = 1;
    int                    proc_fill      = 0;
    logic [COUNT_BITS-1:0] violation_sum  = '0;
    logic [COUNT_BITS-1:0] sandboxed_sum  = '0;

    // Results that are owed by the block, oldest first.
    verdict_t pending_verdicts[$];

    int mismatch_count = 0;
    int idle_cycles    = 0;
    bit burst_mode     = 1'b0;

    initial begin
        ns_type_copy[ROOT_NS]   = ALL_TYPES;
        ns_policy_copy[ROOT_NS] = POL_GRANTED;
    end

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] value);
        return (value == COUNT_MAX) ? value : value + 1'b1;
    endfunction

    // Works out the result of one item and applies its effect on the tables.
    function automatic verdict_t apply_request(input request_t r);
        verdict_t            v;
        logic [NS_IDX_W-1:0] home_of_slot;
        v = '{ok: 1'b0, idx: '0, acc: POL_DENIED, iso: ISO_UNKNOWN,
              violations: '0, sandboxed: '0};
        case (r.op)
            OP_CREATE: begin
                if (ns_fill < MAX_NS) begin
                    ns_type_copy[ns_fill]   = r.type_bits;
                    ns_policy_copy[ns_fill] = (r.policy == POL_UNDEFINED) ? POL_DENIED
                                                                          : r.policy;
                    v.idx = IDX_W'(ns_fill);
                    v.ok  = 1'b1;
                    ns_fill++;
                end
            end
            OP_SPAWN: begin
                if (proc_fill < MAX_PROCS && r.home < ns_fill &&
                    !(r.home == ROOT_NS && !r.caps[ROOT_CAP_BIT])) begin
                    proc_home_copy[proc_fill] = r.home;
                    proc_caps_copy[proc_fill] = r.caps;
                    v.idx = IDX_W'(proc_fill);
                    v.ok  = 1'b1;
                    proc_fill++;
                end
            end
            OP_CHECK: begin
                if (r.slot < proc_fill && r.target < ns_fill) begin
                    home_of_slot = proc_home_copy[r.slot];
                    v.ok = 1'b1;
                    if (home_of_slot == ROOT_NS) begin
                        // Root reaches everything; leaving root is still audited.
                        if (r.target != ROOT_NS) sandboxed_sum = sat_inc(sandboxed_sum);
                        v.acc = POL_GRANTED;
                    end else if (home_of_slot == r.target) begin
                        v.acc = ns_policy_copy[r.target];
                    end else if ((proc_caps_copy[r.slot] & ns_type_copy[r.target]) != '0) begin
                        sandboxed_sum = sat_inc(sandboxed_sum);
                        v.acc = POL_SANDBOXED;
                    end else begin
                        violation_sum = sat_inc(violation_sum);
                        v.acc = POL_DENIED;
                    end
                end
            end
            default: ;
        endcase
        if (r.slot < proc_fill) begin
            v.iso = (proc_home_copy[r.slot] != ROOT_NS) ? ISO_ISOLATED : ISO_SHARED;
        end
        v.violations = violation_sum[TOTAL_W-1:0];
        v.sandboxed  = sandboxed_sum[TOTAL_W-1:0];
        return v;
    endfunction

    function automatic request_t make_request(input t_op op, input int type_bits,
                                              input int policy, input int home,
                                              input int caps, input int slot,
                                              input int target);
        request_t r;
        r.op        = op;
        r.type_bits = TYPE_W'(type_bits);
        r.policy    = POL_W'(policy);
        r.home      = NS_IDX_W'(home);
        r.caps      = CAP_W'(caps);
        r.slot      = PROC_IDX_W'(slot);
        r.target    = NS_IDX_W'(target);
        return r;
    endfunction

    function automatic int draw_gap();
        return burst_mode ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    // Presents one item after a gap of idle cycles, waits for the handshake and records
    // the result that the item must give. Inputs change only at falling edges, and start
    // stays high from one item to the next when there is no gap.
    task automatic issue_request(input request_t r, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start              <= 1'b1;
        i_operation        <= r.op;
        i_new_type_mask    <= r.type_bits;
        i_new_policy       <= r.policy;
        i_home_ns          <= r.home;
        i_capability_bits  <= r.caps;
        i_process_slot     <= r.slot;
        i_target_namespace <= r.target;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_verdicts.push_back(apply_request(r));
    endtask

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        if (mismatch_count < REPORT_LINES) begin
            $display("MISMATCH %s: got %0d, expected %0d, at %0t", field, got, want, $time);
        end
        mismatch_count++;
    endtask

    // Every strobe is matched against the oldest owed result, one field at a time.
    always @(posedge i_clk) begin : result_checker
        verdict_t want;
        if (o_strobe === 1'b1) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("strobe with no item outstanding", 1, 0);
            end else begin
                want = pending_verdicts.pop_front();
                if (o_ok !== want.ok) report_mismatch("ok", o_ok, want.ok);
                if (o_assigned_index !== want.idx) begin
                    report_mismatch("assigned_index", o_assigned_index, want.idx);
                end
                if (o_access_result !== want.acc) begin
                    report_mismatch("access_result", o_access_result, want.acc);
                end
                if (o_isolation !== want.iso) report_mismatch("isolation", o_isolation, want.iso);
                if (o_violation_total !== want.violations) begin
                    report_mismatch("violation_total", o_violation_total, want.violations);
                end
                if (o_sandboxed_total !== want.sandboxed) begin
                    report_mismatch("sandboxed_total", o_sandboxed_total, want.sandboxed);
                end
            end
        end
    end

    // Watchdog: any cycle with neither a handshake nor a result counts towards the limit.
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_strobe === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Builds small tables with known contents and walks through each decision path:
    // the empty process table, the spawn refusals for a bad home or root capability,
    // policy code three being stored as denied, root reaching root and leaving root,
    // each same-namespace policy, the capability overlap and the denial, invalid slots
    // and targets, and the unused operation code with every field at its top value.
    task automatic test_directed();
        issue_request(make_request(OP_CHECK,  0, 0,  0,  0,  0,  0), draw_gap());
        issue_request(make_request(OP_NONE,  15, 3, 15, 31, 31, 15), draw_gap());
        issue_request(make_request(OP_SPAWN,  0, 0,  0, 15,  0,  0), draw_gap());
        issue_request(make_request(OP_SPAWN,  0, 0,  1, 31,  0,  0), draw_gap());
        issue_request(make_request(OP_SPAWN,  0, 0,  0, 31,  0,  0), draw_gap());
        issue_request(make_request(OP_CREATE, 0, POL_UNDEFINED, 0, 0, 0, 0), draw_gap());
        issue_request(make_request(OP_CREATE, 15, POL_SANDBOXED, 0, 0, 0, 0), 0);
        issue_request(make_request(OP_CREATE, 5, POL_GRANTED, 0, 0, 0, 0), 0);
        issue_request(make_request(OP_SPAWN,  0, 0,  1,  0,  0,  0), draw_gap());
        issue_request(make_request(OP_SPAWN,  0, 0,  2, 10,  0,  0), draw_gap());
        issue_request(make_request(OP_SPAWN,  0, 0,  3,  2,  0,  0), 0);
        issue_request(make_request(OP_CHECK,  0, 0,  0,  0,  0,  0), draw_gap());
        issue_request(make_request(OP_CHECK,  0, 0,  0,  0,  0,  2), 0);
        issue_request(make_request(OP_CHECK,  0, 0,  0,  0,  1,  1), draw_gap());
        issue_request(make_request(OP_CHECK,  0, 0,  0,  0,  2,  2), 0);
        issue_request(make_request(OP_CHECK,  0, 0,  0,  0,  3,  3), draw_gap());
        issue_request(make_request(OP_CHECK,  0, 0,  0,  0,  2,  3), 0);
        issue_request(make_request(OP_CHECK,  0, 0,  0,  0,  3,  2), 0);
        issue_request(make_request(OP_CHECK,  0, 0,  0,  0,  1,  0), draw_gap());
        issue_request(make_request(OP_CHECK,  0, 0,  0,  0,  2,  1), 0);
        issue_request(make_request(OP_CHECK,  0, 0,  0,  0, 31,  0), draw_gap());
        issue_request(make_request(OP_CHECK,  0, 0,  0,  0,  2, 15), 0);
        issue_request(make_request(OP_NONE,   0, 0,  0,  0,  2,  0), draw_gap());
    endtask

    // Mostly well-formed items with random content: spawns mostly aim at existing
    // namespaces, checks mostly name live slots and targets and often aim at the home
    // namespace. The fields that an operation ignores are random as well.
    function automatic request_t make_random_request();
        request_t r;
        int       roll;
        bit       full;
        r = make_request(OP_NONE, $urandom_range(0, 15), $urandom_range(0, 3),
                         $urandom_range(0, 15), $urandom_range(0, 31),
                         $urandom_range(0, MAX_PROCS - 1), $urandom_range(0, 15));
        full = (ns_fill == MAX_NS) && (proc_fill == MAX_PROCS);
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            r.op = OP_NONE;
        end else if (roll < (full ? 10 : 20)) begin
            r.op = OP_CREATE;
        end else if (roll < (full ? 15 : 45)) begin
            r.op = OP_SPAWN;
            if ($urandom_range(0, 99) < 85) r.home = NS_IDX_W'($urandom_range(0, ns_fill - 1));
            if (r.home == ROOT_NS && $urandom_range(0, 3) != 0) r.caps[ROOT_CAP_BIT] = 1'b1;
        end else begin
            r.op = OP_CHECK;
            if (proc_fill > 0 && $urandom_range(0, 99) < 85) begin
                r.slot = PROC_IDX_W'($urandom_range(0, proc_fill - 1));
            end
            if ($urandom_range(0, 99) < 85) begin
                r.target = NS_IDX_W'($urandom_range(0, ns_fill - 1));
            end
            if (r.slot < proc_fill && $urandom_range(0, 3) == 0) begin
                r.target = proc_home_copy[r.slot];
            end
        end
        return r;
    endfunction

    task automatic test_random();
        request_t r;
        int       counted;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            // Now and then switch between gapped traffic and back-to-back bursts.
            if ($urandom_range(0, 49) == 0) burst_mode = !burst_mode;
            r = make_random_request();
            counted++;
            issue_request(r, draw_gap());
        end
        burst_mode = 1'b0;
    endtask

    // Fills both tables to the brim and then asks for more, so that a full namespace
    // table and a full process table each refuse an otherwise valid request.
    task automatic test_table_full();
        while (ns_fill < MAX_NS) begin
            issue_request(make_request(OP_CREATE, $urandom_range(0, 15), $urandom_range(0, 3),
                                       0, 0, 0, 0), draw_gap());
        end
        repeat (2) begin
            issue_request(make_request(OP_CREATE, $urandom_range(0, 15), $urandom_range(0, 3),
                                       0, 0, 0, 0), draw_gap());
        end
        while (proc_fill < MAX_PROCS) begin
            issue_request(make_request(OP_SPAWN, 0, 0, $urandom_range(1, ns_fill - 1),
                                       $urandom_range(0, 31), 0, 0), draw_gap());
        end
        repeat (2) begin
            issue_request(make_request(OP_SPAWN, 0, 0, $urandom_range(1, ns_fill - 1),
                                       $urandom_range(0, 31), 0, 0), draw_gap());
        end
    endtask

    // Back-to-back checks that move the totals on every item: the closed slot is always
    // denied when it reaches root, and the root slot leaving root is always counted as
    // sandboxed.
    task automatic test_back_to_back_checks();
        for (int n = 0; n < BURST_ROUNDS; n++) begin
            issue_request(make_request(OP_CHECK, $urandom_range(0, 15), $urandom_range(0, 3),
                                       $urandom_range(0, 15), $urandom_range(0, 31),
                                       CLOSED_SLOT, ROOT_NS), 0);
            issue_request(make_request(OP_CHECK, $urandom_range(0, 15), $urandom_range(0, 3),
                                       $urandom_range(0, 15), $urandom_range(0, 31),
                                       ROOT_SLOT, FOREIGN_NS), 0);
        end
    endtask

    // Main sequence: one reset, then each test in turn. Once the last item has been
    // taken, start is dropped, every owed result is awaited and a few more cycles are
    // allowed for any stray strobe before the verdict is printed.
    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random();
        test_table_full();
        test_back_to_back_checks();

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/nac_pkg.sv
rtl/core/nac_ns_table.sv
rtl/core/nac_proc_table.sv
rtl/core/nac_decide.sv
rtl/core/namespace_access_checker_top.sv
verif/tb_top.sv
